// File: src/kwsm_pkg.sv
// Shared types, codes and default sizes for the k-way sorted merge unit.
package kwsm_pkg;

    localparam int LANES_DEF       = 8;
    localparam int LANE_DEPTH_DEF  = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int LANE_FIELD_W  = 3;
    localparam int VALUE_FIELD_W = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_TAKE   = 1'b1;

    typedef enum logic [1:0] {
        STAT_TAKEN    = 2'd0,
        STAT_APPENDED = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_DROP,
        OP_TAKE
    } op_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        logic                            req_type;
        logic [LANE_FIELD_W-1:0]         lane;
        logic signed [VALUE_FIELD_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_FIELD_W-1:0] out_value;
        logic [LANE_FIELD_W-1:0]         out_lane;
        status_t                         status;
    } out_word_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic [LANE_FIELD_W-1:0]  lane;
        logic [VALUE_FIELD_W-1:0] value;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } queue_head_t;

endpackage

// File: src/k_way_sorted_merge_unit.sv
// Top level of the k-way sorted merge unit: front end, request queue and back end.
//
// Usage: the request channel (req_valid, req_ready, req) carries one word per
// operation. A word with req_type append stores value at the tail of the named
// lane; a word with req_type take removes the smallest head value over all
// lanes, lowest lane first on ties. Every request word yields exactly one word
// on the response channel (rsp_valid, rsp_ready, rsp) in request order.
// The front end holds up to two requests in a queue ahead of the back end.
// An append passes through the exec state of the back end into the response
// register. A take scans the lane heads one lane per cycle through the lane
// RAM read port in the scan state, then passes the drain state and the exec
// state before its response is registered.
// After reset every lane is empty and the queue is empty; req_ready is high.
// Lane storage needs no clearing pass. When the receiver holds rsp_ready low,
// the response register keeps its word, the back end waits with the next
// result, and req_ready falls once the queue is full.
module k_way_sorted_merge_unit #(
    parameter int LANES       = kwsm_pkg::LANES_DEF,
    parameter int LANE_DEPTH  = kwsm_pkg::LANE_DEPTH_DEF,
    parameter int VALUE_WIDTH = kwsm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  kwsm_pkg::in_word_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output kwsm_pkg::out_word_t rsp
);

    import kwsm_pkg::*;

    queue_head_t head;
    logic        pop;

    kwsm_front #(
        .LANES (LANES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .head      (head),
        .pop       (pop)
    );

    kwsm_back #(
        .LANES       (LANES),
        .LANE_DEPTH  (LANE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// File: src/kwsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/kwsm_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
module kwsm_front #(
    parameter int LANES = kwsm_pkg::LANES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  kwsm_pkg::in_word_t    req,
    output kwsm_pkg::queue_head_t head,
    input  logic                  pop
);

    import kwsm_pkg::*;

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    op_t             slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QP_W-1:0] rd_ptr_next;
    logic [QC_W-1:0] fill_reg;
    logic [QC_W-1:0] fill_next;
    op_t             op_in;
    logic            push;

    always_comb
    begin
        op_in.lane  = req.lane;
        op_in.value = req.value;
        priority if (req.req_type == REQ_TAKE)
        begin
            op_in.kind = OP_TAKE;
        end
        else if (int'(req.lane) >= LANES)
        begin
            op_in.kind = OP_DROP;
        end
        else
        begin
            op_in.kind = OP_APPEND;
        end
    end

    assign req_ready = (fill_reg != QC_W'(QUEUE_DEPTH));
    assign push      = req_valid && req_ready;

    assign head.valid = (fill_reg != '0);
    assign head.op    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= op_in;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QC_W'(QUEUE_DEPTH))
        else $error("Request queue fill exceeds its depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("Request queue popped while empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("Request queue fill did not grow on a push.");

endmodule

// File: src/kwsm_back.sv
// Back end: lane pointers, lane storage, min-select scan and the result register.
module kwsm_back #(
    parameter int LANES       = kwsm_pkg::LANES_DEF,
    parameter int LANE_DEPTH  = kwsm_pkg::LANE_DEPTH_DEF,
    parameter int VALUE_WIDTH = kwsm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kwsm_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output kwsm_pkg::out_word_t   rsp
);

    import kwsm_pkg::*;

    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int SLOT_W = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LANE_DEPTH + 1);
    localparam int SW     = (VALUE_WIDTH < VALUE_FIELD_W) ? VALUE_WIDTH : VALUE_FIELD_W;
    localparam int ADDR_W = LANE_W + SLOT_W;
    localparam int RAM_DEPTH = LANES * (2 ** SLOT_W);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [LANE_W-1:0] idx_reg;
    logic [LANE_W-1:0] idx_next;
    op_t               cur_reg;
    op_t               cur_next;
    logic              found_reg;
    logic              found_next;
    logic [SW-1:0]     best_val_reg;
    logic [SW-1:0]     best_val_next;
    logic [LANE_W-1:0] best_lane_reg;
    logic [LANE_W-1:0] best_lane_next;
    logic              pipe_valid_reg;
    logic              pipe_valid_next;
    logic [LANE_W-1:0] pipe_lane_reg;
    logic [LANE_W-1:0] pipe_lane_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_word_t         out_reg;
    out_word_t         out_next;

    logic [SLOT_W-1:0] wp_reg  [LANES];
    logic [SLOT_W-1:0] rp_reg  [LANES];
    logic [CNT_W-1:0]  cnt_reg [LANES];

    logic              do_push;
    logic              do_pop;
    logic              produce;
    logic              out_free;
    logic              take_this;
    logic [SW-1:0]     rdata;
    logic [SLOT_W-1:0] cur_wp;
    logic [SLOT_W-1:0] cur_rp;
    logic [CNT_W-1:0]  cur_cnt;

    assign cur_wp  = wp_reg[idx_reg];
    assign cur_rp  = rp_reg[idx_reg];
    assign cur_cnt = cnt_reg[idx_reg];

    kwsm_ram #(
        .WIDTH (SW),
        .DEPTH (RAM_DEPTH)
    ) u_lane_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (ADDR_W'({idx_reg, cur_wp})),
        .wdata (SW'(cur_reg.value)),
        .raddr (ADDR_W'({idx_reg, cur_rp})),
        .rdata (rdata)
    );

    assign out_free  = !out_valid_reg || rsp_ready;
    assign take_this = pipe_valid_reg &&
                       (!found_reg || ($signed(rdata) < $signed(best_val_reg)));

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        found_next      = found_reg;
        best_val_next   = best_val_reg;
        best_lane_next  = best_lane_reg;
        pipe_valid_next = 1'b0;
        pipe_lane_next  = pipe_lane_reg;
        out_next        = out_reg;
        pop             = 1'b0;
        do_push         = 1'b0;
        do_pop          = 1'b0;
        produce         = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cur_next = head.op;
                    if (head.op.kind == OP_TAKE)
                    begin
                        idx_next       = '0;
                        found_next     = 1'b0;
                        best_lane_next = '0;
                        state_next     = BK_SCAN;
                    end
                    else
                    begin
                        idx_next   = LANE_W'(head.op.lane);
                        state_next = BK_EXEC;
                    end
                end
            end
            BK_SCAN:
            begin
                if (take_this)
                begin
                    found_next     = 1'b1;
                    best_val_next  = rdata;
                    best_lane_next = pipe_lane_reg;
                end
                pipe_valid_next = (cur_cnt != '0);
                pipe_lane_next  = idx_reg;
                if (idx_reg == LANE_W'(LANES - 1))
                begin
                    state_next = BK_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            BK_DRAIN:
            begin
                if (take_this)
                begin
                    found_next     = 1'b1;
                    best_val_next  = rdata;
                    best_lane_next = pipe_lane_reg;
                    idx_next       = pipe_lane_reg;
                end
                else
                begin
                    idx_next = best_lane_reg;
                end
                state_next = BK_EXEC;
            end
            BK_EXEC:
            begin
                if (out_free)
                begin
                    produce            = 1'b1;
                    out_next.out_value = '0;
                    out_next.out_lane  = '0;
                    state_next         = BK_IDLE;
                    unique case (cur_reg.kind)
                        OP_APPEND:
                        begin
                            if (cur_cnt == CNT_W'(LANE_DEPTH))
                            begin
                                out_next.status = STAT_FULL;
                            end
                            else
                            begin
                                do_push         = 1'b1;
                                out_next.status = STAT_APPENDED;
                            end
                        end
                        OP_TAKE:
                        begin
                            if (found_reg)
                            begin
                                do_pop             = 1'b1;
                                out_next.status    = STAT_TAKEN;
                                out_next.out_value = VALUE_FIELD_W'($signed(best_val_reg));
                                out_next.out_lane  = LANE_FIELD_W'(idx_reg);
                            end
                            else
                            begin
                                out_next.status = STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            out_next.status = STAT_FULL;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !rsp_ready) || produce;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                wp_reg[i]  <= '0;
                rp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
            if (do_push)
            begin
                wp_reg[idx_reg]  <= (cur_wp == SLOT_W'(LANE_DEPTH - 1)) ? '0 : cur_wp + 1'b1;
                cnt_reg[idx_reg] <= cur_cnt + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg[idx_reg]  <= (cur_rp == SLOT_W'(LANE_DEPTH - 1)) ? '0 : cur_rp + 1'b1;
                cnt_reg[idx_reg] <= cur_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        best_val_reg   <= best_val_next;
        best_lane_reg  <= best_lane_next;
        pipe_lane_reg  <= pipe_lane_next;
        out_reg        <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cur_cnt <= CNT_W'(LANE_DEPTH))
        else $error("Lane occupancy exceeds the lane depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(do_push && do_pop))
        else $error("Append and take committed in the same cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        do_pop |-> (cur_cnt != '0))
        else $error("Take popped an empty lane.");

    assert property (@(posedge clk) disable iff (!rst_n)
        produce |-> (!out_valid_reg || rsp_ready))
        else $error("Result overwrote a word that was not yet taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN && idx_reg != LANE_W'(LANES - 1))
            |=> (idx_reg == $past(idx_reg) + 1'b1))
        else $error("Lane scan skipped a lane.");

endmodule
